// ===== hdl/tgft_pkg.sv =====
`default_nettype none
package tgft_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_SPEED   = 3'd0;
  localparam logic [2:0] REG_HEADING = 3'd1;
  localparam logic [2:0] REG_LIFT    = 3'd2;
  localparam logic [2:0] REG_STRIDE  = 3'd3;
  localparam logic [2:0] REG_PERIOD  = 3'd4;

  localparam logic [8:0]         RST_SPEED   = 9'd128;
  localparam logic signed [12:0] RST_HEADING = 13'sd0;
  localparam logic [14:0]        RST_LIFT    = 15'd480;
  localparam logic [14:0]        RST_STRIDE  = 15'd640;
  localparam logic [15:0]        RST_PERIOD  = 16'd500;

  localparam logic signed [15:0] STANCE_Z = 16'sd960;

  typedef struct packed {
    logic [8:0]         speed_fraction;
    logic signed [12:0] heading_deg16;
    logic [14:0]        lift_height;
    logic [14:0]        stride;
    logic [15:0]        base_period_ms;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [5:0]  steps;
    logic [15:0] rem_init;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] quot;
  } div_sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) r = 16'sd32767;
    else if (v < -22'sd32768) r = -16'sd32768;
    else r = 16'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tgft_if.sv =====
`default_nettype none
interface tgft_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [31:0] now_ms;
  modport source (output valid, operation, now_ms, input ready);
  modport sink (input valid, operation, now_ms, output ready);
endinterface

interface tgft_foot_if;
  logic              valid;
  logic              ready;
  logic [1:0]        leg_index;
  logic signed [15:0] foot_x;
  logic signed [15:0] foot_y;
  logic signed [15:0] foot_z;
  logic              last_leg;
  modport source (output valid, leg_index, foot_x, foot_y, foot_z, last_leg, input ready);
  modport sink (input valid, leg_index, foot_x, foot_y, foot_z, last_leg, output ready);
endinterface
`default_nettype wire

// ===== hdl/trot_gait_foot_trajectory.sv =====
`default_nettype none
// Sequence: a running update is divided for the phase duration, then (except on a phase
// change) for the phase fraction, then takes 21 multiplier steps before its leg results.
// Flow: one input transaction at a time; a start or an update while stopped needs no output,
// a stop or a running update needs four output transactions before the next input is accepted.
// Reset (rst, synchronous): stopped, phase start and phase bit zero, all legs in
// stance, registers at their documented defaults.
module trot_gait_foot_trajectory #(
  parameter int SINE_TABLE_BITS = tgft_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tgft_cmd_if.sink         cmd,
  tgft_foot_if.source      foot,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int B = SINE_TABLE_BITS;
  localparam int N = 1 << B;
  localparam int Q = N / 4;

  // Reciprocal of 45 scaled by 2^26; exact for every numerator below 2^20.
  localparam logic [20:0] HK_RECIP = 21'd1491309;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DADJ = 3'd1;
  localparam logic [2:0] ST_ELAP = 3'd2;
  localparam logic [2:0] ST_DP   = 3'd3;
  localparam logic [2:0] ST_HDIV = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  // Multiplier steps. Each sine evaluation takes four consecutive steps.
  localparam logic [4:0] M_EASE = 5'd0;
  localparam logic [4:0] M_KIDX = 5'd1;
  localparam logic [4:0] SIN_A  = 5'd2;
  localparam logic [4:0] M_LIFT = 5'd6;
  localparam logic [4:0] SIN_B  = 5'd7;
  localparam logic [4:0] M_COS  = 5'd11;
  localparam logic [4:0] SIN_C  = 5'd12;
  localparam logic [4:0] M_XS   = 5'd16;
  localparam logic [4:0] M_RXP  = 5'd17;
  localparam logic [4:0] M_RXN  = 5'd18;
  localparam logic [4:0] M_RYP  = 5'd19;
  localparam logic [4:0] M_RYN  = 5'd20;

  tgft_pkg::cfg_t     cfg;
  tgft_pkg::div_cmd_t dcmd;
  tgft_pkg::div_sts_t dsts;

  tgft_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  tgft_div u_div (.clk(clk), .rst(rst), .cmd(dcmd), .sts(dsts));

  // Control state.
  logic [2:0]  state;
  logic [4:0]  step;
  logic [1:0]  leg;
  logic        running;
  logic        phase_bit;
  logic [31:0] phase_start_ms;
  logic [3:0]  swing_flags;
  logic        stop_mode;

  // Datapath registers.
  logic [31:0]        now_r;
  logic [15:0]        p;
  logic [16:0]        e;
  logic [B-1:0]       ang;
  logic [B-1:0]       hk;
  logic [14:0]        u2;
  logic [14:0]        t;
  logic signed [15:0] sv;
  logic signed [15:0] sn;
  logic signed [15:0] cs;
  logic signed [15:0] lift;
  logic [14:0]        xs;
  logic signed [15:0] rxp, rxn, ryp, ryn;

  logic cmd_take, foot_take;
  assign cmd.ready = (state == ST_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;
  assign foot_take = foot.valid && foot.ready;

  // Phase duration operands: 2560*base over 10*s + 256, with s clamped to 256.
  logic [8:0]  s_cl;
  logic [12:0] den;
  logic [27:0] num;
  assign s_cl = (cfg.speed_fraction > 9'd256) ? 9'd256 : cfg.speed_fraction;
  assign den  = {1'b0, s_cl, 3'd0} + {3'd0, s_cl, 1'd0} + 13'd256;
  assign num  = {1'b0, cfg.base_period_ms, 11'd0} + {3'd0, cfg.base_period_ms, 9'd0};

  // The duration saturates to 16 bits; a zero duration or an elapsed time at or
  // past it ends the phase.
  logic [15:0] adj;
  logic [31:0] elapsed;
  logic        wrap;
  assign adj     = (|dsts.quot[31:16]) ? 16'hFFFF : dsts.quot[15:0];
  assign elapsed = now_r - phase_start_ms;
  assign wrap    = (adj == 16'd0) || (elapsed >= {16'd0, adj});

  // Heading brought into 0..5759, then its table index is round(h*N/5760).
  // Since 5760 is 128*45, the sum is shifted down by seven and divided by 45
  // through a reciprocal multiplication.
  logic signed [13:0] h;
  logic [31:0]        hx;
  logic [19:0]        hy;
  logic [40:0]        hprod;
  logic [B-1:0]       hk_calc;
  always_comb begin
    h = 14'(cfg.heading_deg16);
    if (h > 14'sd2880) h = h - 14'sd5760;
    if (h < -14'sd2880) h = h + 14'sd5760;
    if (h < 14'sd0) h = h + 14'sd5760;
    hx = (32'(unsigned'(h)) << B) + 32'd2880;
  end
  assign hy      = hx[26:7];
  assign hprod   = {21'd0, hy} * {20'd0, HK_RECIP};
  assign hk_calc = hprod[26 +: B];

  always_comb begin
    dcmd.start    = 1'b0;
    dcmd.steps    = 6'd32;
    dcmd.rem_init = 16'd0;
    dcmd.dividend = {4'd0, num};
    dcmd.divisor  = {3'd0, den};
    case (state)
      ST_IDLE: begin
        if (cmd_take && cmd.operation == tgft_pkg::OP_UPDATE && running) begin
          dcmd.start = 1'b1;
        end
      end
      ST_ELAP: begin
        if (!wrap) begin
          dcmd.start    = 1'b1;
          dcmd.steps    = 6'd16;
          dcmd.rem_init = elapsed[15:0];
          dcmd.dividend = 32'd0;
          dcmd.divisor  = adj;
        end
      end
      default: ;
    endcase
  end

  // Quarter-wave argument from the current angle index.
  logic [1:0]   quad;
  logic [B-3:0] rq;
  logic [B-2:0] us;
  logic [14:0]  u;
  assign quad = ang[B-1:B-2];
  assign rq   = ang[B-3:0];
  assign us   = quad[0] ? ((B-1)'(Q) - {1'b0, rq}) : {1'b0, rq};
  assign u    = 15'(us) << (16 - B);

  // Ease term and the lift angle index.
  logic [16:0] pe;
  logic [17:0] ksum;
  assign pe   = p[15] ? (17'h10000 - {1'b0, p}) : {1'b0, p};
  assign ksum = {1'b0, e} + 18'(1 << (16 - B));

  // The shared multiplier.
  logic signed [17:0] ma, mb;
  logic signed [35:0] prod;
  logic signed [21:0] m14;
  logic signed [35:0] rsum;
  assign prod = ma * mb;
  assign m14  = prod[35:14];
  assign rsum = prod + 36'sd8192;

  always_comb begin
    ma = 18'sd0;
    mb = 18'sd0;
    case (step)
      M_EASE: begin
        ma = $signed({1'b0, pe});
        mb = $signed({1'b0, pe});
      end
      SIN_A, SIN_B, SIN_C: begin
        ma = $signed({3'd0, u});
        mb = $signed({3'd0, u});
      end
      SIN_A + 5'd1, SIN_B + 5'd1, SIN_C + 5'd1: begin
        ma = 18'sd1160;
        mb = $signed({3'd0, u2});
      end
      SIN_A + 5'd2, SIN_B + 5'd2, SIN_C + 5'd2: begin
        ma = $signed({3'd0, t});
        mb = $signed({3'd0, u2});
      end
      SIN_A + 5'd3, SIN_B + 5'd3, SIN_C + 5'd3: begin
        ma = $signed({3'd0, t});
        mb = $signed({3'd0, u});
      end
      M_LIFT: begin
        ma = $signed({3'd0, cfg.lift_height});
        mb = 18'(sv);
      end
      M_XS: begin
        ma = $signed({3'd0, cfg.stride});
        mb = $signed({2'd0, p});
      end
      M_RXP: begin
        ma = $signed({3'd0, xs});
        mb = 18'(cs);
      end
      M_RXN: begin
        ma = -$signed({3'd0, xs});
        mb = 18'(cs);
      end
      M_RYP: begin
        ma = $signed({3'd0, xs});
        mb = 18'(sn);
      end
      M_RYN: begin
        ma = -$signed({3'd0, xs});
        mb = 18'(sn);
      end
      default: ;
    endcase
  end

  // Sequencer and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= 5'd0;
      leg            <= 2'd0;
      running        <= 1'b0;
      phase_bit      <= 1'b0;
      phase_start_ms <= 32'd0;
      swing_flags    <= 4'd0;
      stop_mode      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            case (cmd.operation)
              tgft_pkg::OP_START: begin
                running        <= 1'b1;
                phase_start_ms <= cmd.now_ms;
                phase_bit      <= 1'b0;
              end
              tgft_pkg::OP_STOP: begin
                running   <= 1'b0;
                stop_mode <= 1'b1;
                leg       <= 2'd0;
                state     <= ST_EMIT;
              end
              tgft_pkg::OP_UPDATE: begin
                if (running) state <= ST_DADJ;
              end
              default: ;
            endcase
          end
        end
        ST_DADJ: begin
          if (!dsts.busy) state <= ST_ELAP;
        end
        ST_ELAP: begin
          if (wrap) begin
            // The pair that was in stance takes over the swing.
            phase_start_ms <= now_r;
            phase_bit      <= !phase_bit;
            swing_flags    <= {phase_bit, !phase_bit, !phase_bit, phase_bit};
            state          <= ST_HDIV;
          end else begin
            state <= ST_DP;
          end
        end
        ST_DP: begin
          if (!dsts.busy) state <= ST_HDIV;
        end
        ST_HDIV: begin
          step  <= M_EASE;
          state <= ST_MUL;
        end
        ST_MUL: begin
          step <= step + 5'd1;
          if (step == M_RYN) begin
            stop_mode <= 1'b0;
            leg       <= 2'd0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (foot_take) begin
            leg <= leg + 2'd1;
            if (leg == 2'd3) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath loads.
  always_ff @(posedge clk) begin
    if (cmd_take) now_r <= cmd.now_ms;
    if (state == ST_ELAP && wrap) p <= 16'd0;
    if (state == ST_DP && !dsts.busy) p <= dsts.quot[15:0];
    if (state == ST_HDIV) hk <= hk_calc;
    if (state == ST_MUL) begin
      case (step)
        M_EASE: e <= p[15] ? (17'h10000 - 17'(prod[35:15])) : 17'(prod[35:15]);
        M_KIDX: ang <= ksum[17-B +: B];
        SIN_A, SIN_B, SIN_C: u2 <= 15'(m14);
        SIN_A + 5'd1, SIN_B + 5'd1, SIN_C + 5'd1: t <= 15'(22'sd10512 - m14);
        SIN_A + 5'd2, SIN_B + 5'd2, SIN_C + 5'd2: t <= 15'(22'sd25736 - m14);
        SIN_A + 5'd3, SIN_B + 5'd3, SIN_C + 5'd3: sv <= quad[1] ? 16'(-m14) : 16'(m14);
        M_LIFT: begin
          lift <= tgft_pkg::sat16(22'(tgft_pkg::STANCE_Z) + m14);
          ang  <= hk;
        end
        M_COS: begin
          sn  <= sv;
          ang <= hk + B'(Q);
        end
        M_XS: begin
          cs <= sv;
          xs <= 15'(prod[35:16]);
        end
        M_RXP: rxp <= tgft_pkg::sat16(rsum[35:14]);
        M_RXN: rxn <= tgft_pkg::sat16(rsum[35:14]);
        M_RYP: ryp <= tgft_pkg::sat16(rsum[35:14]);
        M_RYN: ryn <= tgft_pkg::sat16(rsum[35:14]);
        default: ;
      endcase
    end
  end

  // Result transactions: one per leg, selected from the stored swing and
  // stance positions. A stop reports every foot at the stance point.
  logic swing_leg;
  assign swing_leg = swing_flags[leg];

  always_comb begin
    foot.valid     = (state == ST_EMIT);
    foot.leg_index = leg;
    foot.last_leg  = (leg == 2'd3);
    if (stop_mode) begin
      foot.foot_x = 16'sd0;
      foot.foot_y = 16'sd0;
      foot.foot_z = tgft_pkg::STANCE_Z;
    end else if (swing_leg) begin
      foot.foot_x = rxp;
      foot.foot_y = ryp;
      foot.foot_z = lift;
    end else begin
      foot.foot_x = rxn;
      foot.foot_y = ryn;
      foot.foot_z = tgft_pkg::STANCE_Z;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tgft_regs.sv =====
`default_nettype none
module tgft_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output tgft_pkg::cfg_t   cfg
);

  logic wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_fraction <= tgft_pkg::RST_SPEED;
      cfg.heading_deg16  <= tgft_pkg::RST_HEADING;
      cfg.lift_height    <= tgft_pkg::RST_LIFT;
      cfg.stride         <= tgft_pkg::RST_STRIDE;
      cfg.base_period_ms <= tgft_pkg::RST_PERIOD;
    end else if (wr) begin
      case (paddr[4:2])
        tgft_pkg::REG_SPEED:   cfg.speed_fraction <= pwdata[8:0];
        tgft_pkg::REG_HEADING: cfg.heading_deg16  <= $signed(pwdata[12:0]);
        tgft_pkg::REG_LIFT:    cfg.lift_height    <= pwdata[14:0];
        tgft_pkg::REG_STRIDE:  cfg.stride         <= pwdata[14:0];
        tgft_pkg::REG_PERIOD:  cfg.base_period_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      tgft_pkg::REG_SPEED:   prdata = {23'd0, cfg.speed_fraction};
      tgft_pkg::REG_HEADING: prdata = {19'd0, cfg.heading_deg16};
      tgft_pkg::REG_LIFT:    prdata = {17'd0, cfg.lift_height};
      tgft_pkg::REG_STRIDE:  prdata = {17'd0, cfg.stride};
      tgft_pkg::REG_PERIOD:  prdata = {16'd0, cfg.base_period_ms};
      default:               prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/tgft_div.sv =====
`default_nettype none
module tgft_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  tgft_pkg::div_cmd_t  cmd,
  output tgft_pkg::div_sts_t  sts
);

  // Restoring divider, one quotient bit per cycle. The remainder may start
  // nonzero, which lets a fraction be computed with an all-zero dividend.
  logic        busy;
  logic [5:0]  cnt;
  logic [15:0] rem;
  logic [31:0] dvd;
  logic [15:0] dsr;
  logic [31:0] quo;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, dvd[31]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= cmd.steps;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= cmd.rem_init;
      dvd <= cmd.dividend;
      dsr <= cmd.divisor;
      quo <= 32'd0;
    end else if (busy) begin
      rem <= fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      dvd <= {dvd[30:0], 1'b0};
      quo <= {quo[30:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.quot = quo;

endmodule
`default_nettype wire
